/* hdl/ssad_pkg.sv */
// Shared types, widths, constants and exp tables of the soft-argmax keypoint decoder.
`default_nettype none
package ssad_pkg;

   localparam int LOGIT_W = 16;
   localparam int SUM_W   = 32;
   localparam int WSUM_W  = 44;
   localparam int BIN_W   = 12;
   localparam int ROW_W   = 6;
   localparam int SIZE_W  = 13;
   localparam int POS_W   = 21;
   localparam int EXP_W   = 16;
   localparam int DEN_W   = 40;
   localparam int DVR_W   = 43;
   localparam int DVD_W   = 61;
   localparam int CNT_W   = 6;
   localparam int PROD_W  = WSUM_W + SIZE_W;

   localparam int DEFAULT_ROW_LEN   = 32;
   localparam int DEFAULT_KEYPOINTS = 21;

   localparam logic [SIZE_W-1:0] INPUT_SIZE_RESET = 13'd256;
   localparam logic [POS_W-1:0]  POS_MAX          = 21'h0FFFFF;
   localparam logic [EXP_W-1:0]  ONE_Q15          = 16'd32768;
   localparam logic [15:0]       ROUND_Q15        = 16'd16384;
   localparam logic [7:0]        EXP_INT_LIMIT    = 8'd12;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXP1,
      ST_EXP2,
      ST_UPDATE,
      ST_PREP1,
      ST_PREP2,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef enum logic {
      REG_MODE       = 1'b0,
      REG_INPUT_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic exp1;
      logic exp2;
      logic update;
      logic prep1;
      logic prep2;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_bin;
      logic div_done;
      logic out_free;
   } status_type;

   function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] i);
      logic [EXP_W-1:0] r;
      case (i)
         4'd0:    r = 16'd32768;
         4'd1:    r = 16'd12055;
         4'd2:    r = 16'd4435;
         4'd3:    r = 16'd1631;
         4'd4:    r = 16'd600;
         4'd5:    r = 16'd221;
         4'd6:    r = 16'd81;
         4'd7:    r = 16'd30;
         4'd8:    r = 16'd11;
         4'd9:    r = 16'd4;
         4'd10:   r = 16'd1;
         4'd11:   r = 16'd1;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [EXP_W-1:0] exp_sixteenth(input logic [3:0] k);
      logic [EXP_W-1:0] r;
      case (k)
         4'd0:    r = 16'd32768;
         4'd1:    r = 16'd30783;
         4'd2:    r = 16'd28918;
         4'd3:    r = 16'd27166;
         4'd4:    r = 16'd25520;
         4'd5:    r = 16'd23974;
         4'd6:    r = 16'd22521;
         4'd7:    r = 16'd21157;
         4'd8:    r = 16'd19875;
         4'd9:    r = 16'd18671;
         4'd10:   r = 16'd17540;
         4'd11:   r = 16'd16477;
         4'd12:   r = 16'd15479;
         4'd13:   r = 16'd14541;
         4'd14:   r = 16'd13660;
         default: r = 16'd12832;
      endcase
      return r;
   endfunction

   function automatic logic [EXP_W-1:0] exp_fine(input logic [3:0] k);
      logic [EXP_W-1:0] r;
      case (k)
         4'd0:    r = 16'd32768;
         4'd1:    r = 16'd32640;
         4'd2:    r = 16'd32513;
         4'd3:    r = 16'd32386;
         4'd4:    r = 16'd32260;
         4'd5:    r = 16'd32134;
         4'd6:    r = 16'd32009;
         4'd7:    r = 16'd31884;
         4'd8:    r = 16'd31760;
         4'd9:    r = 16'd31636;
         4'd10:   r = 16'd31513;
         4'd11:   r = 16'd31390;
         4'd12:   r = 16'd31267;
         4'd13:   r = 16'd31146;
         4'd14:   r = 16'd31024;
         default: r = 16'd30903;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/ssad_channels.sv */
// Valid/ready channel interfaces for logits, results and register writes.
`default_nettype none
interface ssad_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [ssad_pkg::LOGIT_W-1:0]  logit;
   modport source (output valid, output logit, input ready);
   modport sink   (input valid, input logit, output ready);
endinterface

interface ssad_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ssad_pkg::ROW_W-1:0]          keypoint;
   logic signed [ssad_pkg::POS_W-1:0]   position;
   logic                                frame_end;
   modport source (output valid, output keypoint, output position, output frame_end,
                   input ready);
   modport sink   (input valid, input keypoint, input position, input frame_end,
                   output ready);
endinterface

interface ssad_csr_if;
   logic                              valid;
   logic                              ready;
   ssad_pkg::csr_index_type           index;
   logic [ssad_pkg::SIZE_W-1:0]       data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/ssad_ctrl.sv */
// Sequencing state machine of the decoder.
`default_nettype none
module ssad_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ssad_pkg::status_type status,
   output ssad_pkg::cmd_type         cmd
);

   ssad_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssad_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ssad_pkg::ST_IDLE:   if (req_valid) state_in = ssad_pkg::ST_EXP1;
         ssad_pkg::ST_EXP1:   state_in = ssad_pkg::ST_EXP2;
         ssad_pkg::ST_EXP2:   state_in = ssad_pkg::ST_UPDATE;
         ssad_pkg::ST_UPDATE: begin
            state_in = status.last_bin ? ssad_pkg::ST_PREP1 : ssad_pkg::ST_IDLE;
         end
         ssad_pkg::ST_PREP1:  state_in = ssad_pkg::ST_PREP2;
         ssad_pkg::ST_PREP2:  state_in = ssad_pkg::ST_DIV;
         ssad_pkg::ST_DIV:    if (status.div_done) state_in = ssad_pkg::ST_FINISH;
         ssad_pkg::ST_FINISH: if (status.out_free) state_in = ssad_pkg::ST_IDLE;
         default:             state_in = ssad_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ssad_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ssad_pkg::ST_EXP1:   cmd.exp1     = 1'b1;
         ssad_pkg::ST_EXP2:   cmd.exp2     = 1'b1;
         ssad_pkg::ST_UPDATE: cmd.update   = 1'b1;
         ssad_pkg::ST_PREP1:  cmd.prep1    = 1'b1;
         ssad_pkg::ST_PREP2:  cmd.prep2    = 1'b1;
         ssad_pkg::ST_DIV:    cmd.div_step = 1'b1;
         ssad_pkg::ST_FINISH: cmd.finish   = status.out_free;
         default:             cmd          = '0;
      endcase
   end

endmodule
`default_nettype wire

/* hdl/ssad_dp.sv */
// Datapath: registers, exp lookup, online softmax sums, divider and result register.
`default_nettype none
module ssad_dp #(
   parameter int ROW_LEN   = ssad_pkg::DEFAULT_ROW_LEN,
   parameter int KEYPOINTS = ssad_pkg::DEFAULT_KEYPOINTS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire ssad_pkg::cmd_type                   cmd,
   output ssad_pkg::status_type                     status,
   input  wire logic signed [ssad_pkg::LOGIT_W-1:0] req_logit,
   input  wire logic                                csr_write,
   input  wire ssad_pkg::csr_index_type             csr_index,
   input  wire logic [ssad_pkg::SIZE_W-1:0]         csr_data,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic [ssad_pkg::ROW_W-1:0]               rsp_keypoint,
   output logic signed [ssad_pkg::POS_W-1:0]        rsp_position,
   output logic                                     rsp_frame_end
);

   localparam int L = ssad_pkg::LOGIT_W;
   localparam int E = ssad_pkg::EXP_W;
   localparam int S = ssad_pkg::SUM_W;
   localparam int W = ssad_pkg::WSUM_W;

   logic                              mode_ff, mode_in;
   logic [ssad_pkg::SIZE_W-1:0]       size_ff, size_in;
   logic                              gt_ff, gt_in;
   logic signed [L-1:0]               x_ff, x_in;
   logic [L-1:0]                      t_ff, t_in;
   logic [E-1:0]                      v_ff, v_in;
   logic [E-1:0]                      e_ff, e_in;
   logic signed [L-1:0]               max_ff, max_in;
   logic [S-1:0]                      s_ff, s_in;
   logic [W-1:0]                      w_ff, w_in;
   logic [ssad_pkg::BIN_W-1:0]        bin_ff, bin_in;
   logic [ssad_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [ssad_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [ssad_pkg::PROD_W-1:0]       prod_ff, prod_in;
   logic                              neg_ff, neg_in;
   logic                              zero_ff, zero_in;
   logic [ssad_pkg::DVD_W-1:0]        dvd_ff, dvd_in;
   logic [ssad_pkg::DVR_W-1:0]        dvr_ff, dvr_in;
   logic [ssad_pkg::DVR_W-1:0]        rem_ff, rem_in;
   logic [ssad_pkg::DVD_W-1:0]        quo_ff, quo_in;
   logic [ssad_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic                              out_valid_ff, out_valid_in;
   logic [ssad_pkg::ROW_W-1:0]        out_kp_ff, out_kp_in;
   logic signed [ssad_pkg::POS_W-1:0] out_pos_ff, out_pos_in;
   logic                              out_end_ff, out_end_in;

   logic signed [L:0]                 diff;
   logic [2*E-1:0]                    prod_ab;
   logic [2*E-1:0]                    prod_vc;
   logic [S+E-1:0]                    prod_sr;
   logic [W+E-1:0]                    prod_wr;
   logic [ssad_pkg::BIN_W+E-1:0]      prod_je;
   logic [ssad_pkg::DEN_W+2:0]        d5;
   logic [W:0]                        two_w;
   logic [W:0]                        mag;
   logic [ssad_pkg::DVR_W:0]          rem_sh;
   logic                              rem_ge;
   logic [ssad_pkg::POS_W-1:0]        q_low;
   logic                              last_row;

   assign last_row = (row_ff == ssad_pkg::ROW_W'(KEYPOINTS - 1));

   assign status.last_bin = (bin_ff == ssad_pkg::BIN_W'(ROW_LEN - 1));
   assign status.div_done = (cnt_ff == ssad_pkg::CNT_W'(ssad_pkg::DVD_W - 1));
   assign status.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      diff    = {req_logit[L-1], req_logit} - {max_ff[L-1], max_ff};
      prod_ab = (2*E)'(ssad_pkg::exp_int(t_ff[11:8]))
                * (2*E)'(ssad_pkg::exp_sixteenth(t_ff[7:4]));
      prod_vc = (2*E)'(v_ff) * (2*E)'(ssad_pkg::exp_fine(t_ff[3:0]));
      prod_sr = (S+E)'(s_ff) * (S+E)'(e_ff);
      prod_wr = (W+E)'(w_ff) * (W+E)'(e_ff);
      prod_je = (ssad_pkg::BIN_W+E)'(bin_ff) * (ssad_pkg::BIN_W+E)'(e_ff);
      d5      = {1'b0, den_ff, 2'b00} + {3'b000, den_ff};
      two_w   = {w_ff, 1'b0};
      mag     = neg_ff ? ((W+1)'(den_ff) - two_w) : (two_w - (W+1)'(den_ff));
      rem_sh  = {rem_ff, dvd_ff[ssad_pkg::DVD_W-1]};
      rem_ge  = rem_sh >= {1'b0, dvr_ff};
      q_low   = quo_ff[ssad_pkg::POS_W-1:0];
   end

   always_comb begin
      mode_in      = mode_ff;
      size_in      = size_ff;
      gt_in        = gt_ff;
      x_in         = x_ff;
      t_in         = t_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      max_in       = max_ff;
      s_in         = s_ff;
      w_in         = w_ff;
      bin_in       = bin_ff;
      row_in       = row_ff;
      den_in       = den_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      dvd_in       = dvd_ff;
      dvr_in       = dvr_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_kp_in    = out_kp_ff;
      out_pos_in   = out_pos_ff;
      out_end_in   = out_end_ff;

      if (csr_write) begin
         case (csr_index)
            ssad_pkg::REG_MODE:       mode_in = csr_data[0];
            ssad_pkg::REG_INPUT_SIZE: size_in = csr_data;
            default:                  size_in = size_ff;
         endcase
      end

      if (cmd.load) begin
         x_in  = req_logit;
         gt_in = req_logit > max_ff;
         t_in  = (req_logit > max_ff) ? diff[L-1:0] : L'(-diff);
      end

      if (cmd.exp1) begin
         if (t_ff[15:8] >= ssad_pkg::EXP_INT_LIMIT) begin
            v_in = '0;
         end else begin
            v_in = E'((prod_ab + (2*E)'(ssad_pkg::ROUND_Q15)) >> 15);
         end
      end

      if (cmd.exp2) begin
         e_in = E'((prod_vc + (2*E)'(ssad_pkg::ROUND_Q15)) >> 15);
      end

      if (cmd.update) begin
         if (gt_ff) begin
            s_in   = S'((prod_sr + (S+E)'(ssad_pkg::ROUND_Q15)) >> 15)
                     + S'(ssad_pkg::ONE_Q15);
            w_in   = W'((prod_wr + (W+E)'(ssad_pkg::ROUND_Q15)) >> 15)
                     + (W'(bin_ff) << 15);
            max_in = x_ff;
         end else begin
            s_in = s_ff + S'(e_ff);
            w_in = w_ff + W'(prod_je);
         end
         if (!status.last_bin) begin
            bin_in = bin_ff + ssad_pkg::BIN_W'(1);
         end
      end

      if (cmd.prep1) begin
         den_in  = ssad_pkg::DEN_W'(ssad_pkg::DEN_W'(s_ff) * ssad_pkg::DEN_W'(ROW_LEN));
         prod_in = ssad_pkg::PROD_W'(w_ff) * ssad_pkg::PROD_W'(size_ff);
         neg_in  = two_w < (W+1)'(s_ff) * (W+1)'(ROW_LEN);
      end

      if (cmd.prep2) begin
         zero_in = (den_ff == '0);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = '0;
         if (!mode_ff) begin
            dvd_in = ssad_pkg::DVD_W'({prod_ff, 8'd0}) + ssad_pkg::DVD_W'(den_ff >> 1);
            dvr_in = ssad_pkg::DVR_W'(den_ff);
         end else begin
            dvd_in = ssad_pkg::DVD_W'({mag, 15'd0}) + ssad_pkg::DVD_W'(d5 >> 1);
            dvr_in = ssad_pkg::DVR_W'(d5);
         end
      end

      if (cmd.div_step) begin
         rem_in = rem_ge ? ssad_pkg::DVR_W'(rem_sh - {1'b0, dvr_ff})
                         : ssad_pkg::DVR_W'(rem_sh);
         quo_in = {quo_ff[ssad_pkg::DVD_W-2:0], rem_ge};
         dvd_in = dvd_ff << 1;
         cnt_in = cnt_ff + ssad_pkg::CNT_W'(1);
      end

      if (cmd.finish) begin
         out_valid_in = 1'b1;
         out_kp_in    = row_ff;
         out_end_in   = last_row;
         if (zero_ff) begin
            out_pos_in = '0;
         end else if (!mode_ff) begin
            out_pos_in = (|quo_ff[ssad_pkg::DVD_W-1:ssad_pkg::POS_W-1])
                         ? ssad_pkg::POS_MAX : q_low;
         end else begin
            out_pos_in = neg_ff ? -q_low : q_low;
         end
         row_in = last_row ? '0 : row_ff + ssad_pkg::ROW_W'(1);
         max_in = {1'b1, {(L-1){1'b0}}};
         s_in   = '0;
         w_in   = '0;
         bin_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         size_ff      <= ssad_pkg::INPUT_SIZE_RESET;
         max_ff       <= {1'b1, {(L-1){1'b0}}};
         s_ff         <= '0;
         w_ff         <= '0;
         bin_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         size_ff      <= size_in;
         max_ff       <= max_in;
         s_ff         <= s_in;
         w_ff         <= w_in;
         bin_ff       <= bin_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gt_ff      <= gt_in;
      x_ff       <= x_in;
      t_ff       <= t_in;
      v_ff       <= v_in;
      e_ff       <= e_in;
      den_ff     <= den_in;
      prod_ff    <= prod_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      dvd_ff     <= dvd_in;
      dvr_ff     <= dvr_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      out_kp_ff  <= out_kp_in;
      out_pos_ff <= out_pos_in;
      out_end_ff <= out_end_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_keypoint  = out_kp_ff;
   assign rsp_position  = out_pos_ff;
   assign rsp_frame_end = out_end_ff;

endmodule
`default_nettype wire

/* hdl/simcc_soft_argmax_decoder.sv */
// Top level of the soft-argmax keypoint decoder.
//
//   channel   direction  transaction
//   req_ch    in         one logit of a heat row
//   rsp_ch    out        keypoint index, position, frame end at each row end
//   csr_ch    in         register write: index 0 mode, index 1 input_size
//
// Each logit steps through accept with the difference to the running max, two
// exp table multiplies, then the rescale multiply-add on the running sums. The
// last logit of a row adds the denominator product, the operand setup, the
// 61-step shift-subtract divider and the result load. Reset is synchronous,
// clears sums, counters and output valid, and resets mode, input_size and max.
// A result waits in the output register while the next row streams in; only the
// next row end stalls until it is taken.
`default_nettype none
module simcc_soft_argmax_decoder #(
   parameter int ROW_LEN   = ssad_pkg::DEFAULT_ROW_LEN,
   parameter int KEYPOINTS = ssad_pkg::DEFAULT_KEYPOINTS
) (
   input wire logic  clock,
   input wire logic  reset,
   ssad_req_if.sink  req_ch,
   ssad_rsp_if.source rsp_ch,
   ssad_csr_if.sink  csr_ch
);

   ssad_pkg::cmd_type    cmd;
   ssad_pkg::status_type status;
   logic                 req_ready;

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   ssad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssad_dp #(
      .ROW_LEN   (ROW_LEN),
      .KEYPOINTS (KEYPOINTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_logit     (req_ch.logit),
      .csr_write     (csr_ch.valid),
      .csr_index     (csr_ch.index),
      .csr_data      (csr_ch.data),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_keypoint  (rsp_ch.keypoint),
      .rsp_position  (rsp_ch.position),
      .rsp_frame_end (rsp_ch.frame_end)
   );

endmodule
`default_nettype wire
